/* src/ucpi_pkg.sv */
// Package for the unicycle pose integrator: field widths, reset constants,
// CORDIC arctangent table and the saturating position update.
// No dependencies.
package ucpi_pkg;

  localparam int PERIOD_W = 16;
  localparam int VEL_W    = 16;
  localparam int ANGV_W   = 24;
  localparam int POS_W    = 32;
  localparam int HEAD_W   = 16;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int CRD_W    = 34;  // CORDIC x/y/z, Q2.30 plus headroom

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 16'd6554;
  localparam logic signed [CRD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic init;   // fold the angle and seed x, y, z
    logic step;   // one micro-rotation
    logic neg;    // undo the half-turn fold
  } ucpi_cordic_ctl_t;

  // atan(2^-i) at 2^32 units per turn
  function automatic logic [31:0] atan_at(input logic [4:0] idx);
    logic [31:0] v;
    begin
      case (idx)
        5'd0:  v = 32'd536870912;
        5'd1:  v = 32'd316933406;
        5'd2:  v = 32'd167458907;
        5'd3:  v = 32'd85004756;
        5'd4:  v = 32'd42667331;
        5'd5:  v = 32'd21354465;
        5'd6:  v = 32'd10679838;
        5'd7:  v = 32'd5340245;
        5'd8:  v = 32'd2670163;
        5'd9:  v = 32'd1335087;
        5'd10: v = 32'd667544;
        5'd11: v = 32'd333772;
        5'd12: v = 32'd166886;
        5'd13: v = 32'd83443;
        5'd14: v = 32'd41722;
        5'd15: v = 32'd20861;
        5'd16: v = 32'd10430;
        5'd17: v = 32'd5215;
        5'd18: v = 32'd2608;
        5'd19: v = 32'd1304;
        5'd20: v = 32'd652;
        5'd21: v = 32'd326;
        5'd22: v = 32'd163;
        5'd23: v = 32'd81;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

  // pos + round(prod / 2^38), half up, clamped to 32-bit signed
  function automatic logic signed [POS_W-1:0] sat_step(
      input logic signed [POS_W-1:0]  pos,
      input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] rnd;
    logic signed [25:0]       delta;
    logic signed [POS_W:0]    sum;
    logic signed [POS_W-1:0]  res;
    begin
      rnd   = prod + (64'sd1 <<< 37);
      delta = rnd[63:38];
      sum   = {pos[POS_W-1], pos} + {{(POS_W - 25){delta[25]}}, delta};
      if (sum[POS_W] != sum[POS_W-1]) begin
        res = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
        res = sum[POS_W-1:0];
      end
      return res;
    end
  endfunction

endpackage

/* src/ucpi_in_if.sv */
// Input channel: valid/ready plus one step or load item.
// Depends on ucpi_pkg.
interface ucpi_in_if;
  import ucpi_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic signed [VEL_W-1:0]    cmd_forward_velocity;
  logic signed [ANGV_W-1:0]   cmd_angular_velocity;
  logic signed [POS_W-1:0]    load_x;
  logic signed [POS_W-1:0]    load_y;
  logic        [HEAD_W-1:0]   load_heading;

  modport source(output valid, opcode, cmd_forward_velocity, cmd_angular_velocity,
                 load_x, load_y, load_heading, input ready);
  modport sink(input valid, opcode, cmd_forward_velocity, cmd_angular_velocity,
               load_x, load_y, load_heading, output ready);
endinterface

/* src/ucpi_out_if.sv */
// Result channel: valid/ready plus pose and echoed velocities.
// Depends on ucpi_pkg.
interface ucpi_out_if;
  import ucpi_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [POS_W-1:0]    out_x;
  logic signed [POS_W-1:0]    out_y;
  logic        [HEAD_W-1:0]   out_heading;
  logic signed [VEL_W-1:0]    out_linear_velocity;
  logic signed [ANGV_W-1:0]   out_angular_velocity;

  modport source(output valid, out_x, out_y, out_heading, out_linear_velocity,
                 out_angular_velocity, input ready);
  modport sink(input valid, out_x, out_y, out_heading, out_linear_velocity,
               out_angular_velocity, output ready);
endinterface

/* src/ucpi_mult.sv */
// Shared 32x32 signed multiplier with registered product.
// Depends on ucpi_pkg.
module ucpi_mult (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ucpi_pkg::MUL_W-1:0]  a,
  input  logic signed [ucpi_pkg::MUL_W-1:0]  b,
  output logic signed [ucpi_pkg::PROD_W-1:0] prod_r
);
  import ucpi_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

/* src/ucpi_cordic.sv */
// Rotation-mode CORDIC, one micro-rotation per cycle, with quadrant fold.
// Depends on ucpi_pkg.
module ucpi_cordic #(
  parameter int IterW        = 4
) (
  input  logic                              clk,
  input  ucpi_pkg::ucpi_cordic_ctl_t        ctl,
  input  logic [ucpi_pkg::HEAD_W-1:0]       angle,
  input  logic [IterW-1:0]                  iter,
  output logic signed [ucpi_pkg::MUL_W-1:0] cos_o,
  output logic signed [ucpi_pkg::MUL_W-1:0] sin_o
);
  import ucpi_pkg::*;

  logic signed [CRD_W-1:0] x_r, y_r, z_r;
  logic                    flip_r;

  logic signed [HEAD_W:0]  a_ext;
  logic signed [HEAD_W:0]  a_fold;
  logic                    fold;
  logic signed [CRD_W-1:0] dx, dy, atan_v;

  always_comb begin
    a_ext  = {angle[HEAD_W-1], angle};
    fold   = 1'b0;
    a_fold = a_ext;
    if (a_ext > 17'sd16384) begin
      a_fold = a_ext - 17'sd32768;
      fold   = 1'b1;
    end else if (a_ext < -17'sd16384) begin
      a_fold = a_ext + 17'sd32768;
      fold   = 1'b1;
    end
    dx     = y_r >>> iter;
    dy     = x_r >>> iter;
    atan_v = {{(CRD_W - 32){1'b0}}, atan_at(5'(iter))};
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      x_r    <= CORDIC_GAIN_Q30;
      y_r    <= '0;
      z_r    <= {a_fold[HEAD_W], a_fold, 16'b0};
      flip_r <= fold;
    end else if (ctl.step) begin
      if (!z_r[CRD_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_v;
      end
    end else if (ctl.neg && flip_r) begin
      x_r <= -x_r;
      y_r <= -y_r;
    end
  end

  // final |x|,|y| stay near 2^30, so 32 bits hold them
  assign cos_o = x_r[MUL_W-1:0];
  assign sin_o = y_r[MUL_W-1:0];

endmodule

/* src/unicycle_pose_integrator_core.sv */
// Unicycle pose integrator top: sequencer, pose state, config register.
// Depends on ucpi_pkg, ucpi_in_if, ucpi_out_if, ucpi_mult, ucpi_cordic.
//
//   channel | dir | handshake           | payload
//   in_ch   | in  | valid/ready         | opcode, velocities, load pose
//   out_ch  | out | valid/ready         | pose, echoed velocities
//   cfg     | in  | cfg_we (no wait)    | step_period in cfg_wdata
//
// A step item passes through TURN, DIST, the CORDIC micro-rotations in ITER
// (one per cycle), FLIP, MULX, MULY and ADDY to the result register in OUT,
// using the single multiplier four times. A load item goes from accept to OUT.
// After OUT each item returns to IDLE, the only state that accepts the next.
// Synchronous active-low reset clears the pose to zero and step_period to
// 6554. A stalled result holds in the output register; the next item is
// accepted meanwhile and waits for it only at its final stage.
module unicycle_pose_integrator_core #(
  parameter int CORDIC_STEPS = ucpi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ucpi_pkg::PERIOD_W-1:0]    cfg_wdata,
  ucpi_in_if.sink                          in_ch,
  ucpi_out_if.source                       out_ch
);
  import ucpi_pkg::*;

  localparam int IterW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TURN = 4'd1;
  localparam logic [3:0] S_DIST = 4'd2;
  localparam logic [3:0] S_ITER = 4'd3;
  localparam logic [3:0] S_FLIP = 4'd4;
  localparam logic [3:0] S_MULX = 4'd5;
  localparam logic [3:0] S_MULY = 4'd6;
  localparam logic [3:0] S_ADDY = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]              state_r, state_nxt;
  logic [IterW-1:0]        iter_r, iter_nxt;
  logic                    out_valid_r;
  logic [PERIOD_W-1:0]     step_r;

  logic signed [POS_W-1:0] pos_x_r, pos_y_r;
  logic [HEAD_W-1:0]       heading_r;

  logic signed [VEL_W-1:0]  vel_r;
  logic signed [ANGV_W-1:0] angv_r;
  logic signed [MUL_W-1:0]  d_r;

  logic signed [POS_W-1:0]  ox_r, oy_r;
  logic [HEAD_W-1:0]        oh_r;
  logic signed [VEL_W-1:0]  ov_r;
  logic signed [ANGV_W-1:0] ow_r;

  logic                     accept;
  logic                     out_load;
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic [MUL_W-1:0]         turn_rnd;
  logic [HEAD_W-1:0]        heading_nxt;
  ucpi_cordic_ctl_t         cordic_ctl;
  logic signed [MUL_W-1:0]  cos_v, sin_v;

  assign accept   = in_ch.valid && (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // heading increment = round half up of w * dt / 2^16
  assign turn_rnd    = prod_r[MUL_W-1:0] + 32'h0000_8000;
  assign heading_nxt = heading_r + turn_rnd[31:16];

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (state_r)
      S_TURN: begin
        mul_a  = {{(MUL_W - ANGV_W){angv_r[ANGV_W-1]}}, angv_r};
        mul_b  = {{(MUL_W - PERIOD_W){1'b0}}, step_r};
        mul_en = 1'b1;
      end
      S_DIST: begin
        mul_a  = {{(MUL_W - VEL_W){vel_r[VEL_W-1]}}, vel_r};
        mul_b  = {{(MUL_W - PERIOD_W){1'b0}}, step_r};
        mul_en = 1'b1;
      end
      S_MULX: begin
        mul_a  = d_r;
        mul_b  = cos_v;
        mul_en = 1'b1;
      end
      S_MULY: begin
        mul_a  = d_r;
        mul_b  = sin_v;
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign cordic_ctl.init = (state_r == S_DIST);
  assign cordic_ctl.step = (state_r == S_ITER);
  assign cordic_ctl.neg  = (state_r == S_FLIP);

  ucpi_mult u_mult (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  ucpi_cordic #(
    .IterW        (IterW)
  ) u_cordic (
    .clk   (clk),
    .ctl   (cordic_ctl),
    .angle (heading_nxt),
    .iter  (iter_r),
    .cos_o (cos_v),
    .sin_o (sin_v)
  );

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.opcode == OP_LOAD) ? S_OUT : S_TURN;
        end
      end
      S_TURN: state_nxt = S_DIST;
      S_DIST: begin
        state_nxt = S_ITER;
        iter_nxt  = '0;
      end
      S_ITER: begin
        if (iter_r == IterW'(CORDIC_STEPS - 1)) begin
          state_nxt = S_FLIP;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      S_FLIP: state_nxt = S_MULX;
      S_MULX: state_nxt = S_MULY;
      S_MULY: state_nxt = S_ADDY;
      S_ADDY: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_PERIOD_RST;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept && (in_ch.opcode == OP_LOAD)) begin
        pos_x_r   <= in_ch.load_x;
        pos_y_r   <= in_ch.load_y;
        heading_r <= in_ch.load_heading;
      end
      if (state_r == S_DIST) begin
        heading_r <= heading_nxt;
      end
      if (state_r == S_MULY) begin
        pos_x_r <= sat_step(pos_x_r, prod_r);
      end
      if (state_r == S_ADDY) begin
        pos_y_r <= sat_step(pos_y_r, prod_r);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_ch.opcode == OP_LOAD) begin
        vel_r  <= '0;
        angv_r <= '0;
      end else begin
        vel_r  <= in_ch.cmd_forward_velocity;
        angv_r <= in_ch.cmd_angular_velocity;
      end
    end
    // distance v*dt sits in prod_r through the CORDIC pass
    if (state_r == S_ITER) begin
      d_r <= prod_r[MUL_W-1:0];
    end
    if (out_load) begin
      ox_r <= pos_x_r;
      oy_r <= pos_y_r;
      oh_r <= heading_r;
      ov_r <= vel_r;
      ow_r <= angv_r;
    end
  end

  assign in_ch.ready                 = (state_r == S_IDLE);
  assign out_ch.valid                = out_valid_r;
  assign out_ch.out_x                = ox_r;
  assign out_ch.out_y                = oy_r;
  assign out_ch.out_heading          = oh_r;
  assign out_ch.out_linear_velocity  = ov_r;
  assign out_ch.out_angular_velocity = ow_r;

endmodule

/* sim/tb.sv */
// Self-checking testbench for unicycle_pose_integrator_core: a directed table, then random
// phases at several step periods, checked against typed rows or an in-bench predictor.
// Depends on ucpi_pkg, ucpi_in_if, ucpi_out_if and the core RTL.
`timescale 1ns / 100ps

module tb;
  import ucpi_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_AT_BEAT = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int PHASE_ITEMS  = 100;
  localparam int ROT_STEPS    = CORDIC_STEPS_DEF;

  // arctangent of 2^-i, 2^32 units per turn
  localparam longint ROT_ANGLE [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
  localparam longint ROT_GAIN = 652032874;

  typedef struct {
    logic                     opcode;
    logic signed [VEL_W-1:0]  fwd;
    logic signed [ANGV_W-1:0] ang;
    logic signed [POS_W-1:0]  lx;
    logic signed [POS_W-1:0]  ly;
    logic [HEAD_W-1:0]        lh;
  } pose_cmd_t;

  typedef struct {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [HEAD_W-1:0]        hd;
    logic signed [VEL_W-1:0]  lin;
    logic signed [ANGV_W-1:0] ang;
  } pose_rpt_t;

  typedef struct {
    logic                set_period;
    logic [PERIOD_W-1:0] period;
    pose_cmd_t           cmd;
    logic                typed;
    pose_rpt_t           want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [PERIOD_W-1:0] cfg_wdata;

  ucpi_in_if  in_ch ();
  ucpi_out_if out_ch ();

  unicycle_pose_integrator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state
  logic [PERIOD_W-1:0]     dt_q16;
  logic signed [POS_W-1:0] pose_x;
  logic signed [POS_W-1:0] pose_y;
  logic [HEAD_W-1:0]       pose_hd;

  pose_rpt_t pose_q [$];
  dir_row_t  dir_tab [$];
  int        errs = 0;
  int        beats = 0;
  int        cycles = 0;
  bit        no_idle;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("unicycle_pose_integrator_core: mismatch");
      $finish;
    end
  end

  // rotation-mode CORDIC, heading folded into +/- a quarter turn
  function automatic void cos_sin(input logic [HEAD_W-1:0] hd, output longint c,
                                  output longint s);
    longint a, x, y, z, dx, dy;
    bit     flip;
    a    = (hd >= 16'd32768) ? longint'(hd) - 65536 : longint'(hd);
    flip = 1'b0;
    if (a > 16384) begin
      a    = a - 32768;
      flip = 1'b1;
    end else if (a < -16384) begin
      a    = a + 32768;
      flip = 1'b1;
    end
    x = ROT_GAIN;
    y = 0;
    z = a * 65536;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ROT_ANGLE[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ROT_ANGLE[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_add(input logic signed [POS_W-1:0] p,
                                                        input longint prod);
    longint r;
    r = longint'(p) + ((prod + (longint'(1) <<< 37)) >>> 38);
    if (r > 64'sd2147483647) return 32'sh7fffffff;
    if (r < -64'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  function automatic pose_rpt_t advance_pose(input pose_cmd_t cmd);
    pose_rpt_t   r;
    longint      dt, turn, travel, c, s;
    logic [63:0] tv;
    r.lin = '0;
    r.ang = '0;
    if (cmd.opcode == OP_LOAD) begin
      pose_x  = cmd.lx;
      pose_y  = cmd.ly;
      pose_hd = cmd.lh;
    end else begin
      dt      = longint'(dt_q16);
      turn    = longint'(cmd.ang) * dt + 32768;
      tv      = turn;
      pose_hd = pose_hd + tv[31:16];
      travel  = longint'(cmd.fwd) * dt;
      cos_sin(pose_hd, c, s);
      pose_x  = clamp_add(pose_x, travel * c);
      pose_y  = clamp_add(pose_y, travel * s);
      r.lin   = cmd.fwd;
      r.ang   = cmd.ang;
    end
    r.x  = pose_x;
    r.y  = pose_y;
    r.hd = pose_hd;
    return r;
  endfunction

  task automatic send_cmd(input pose_cmd_t cmd, input logic typed, input pose_rpt_t want);
    int        gap;
    pose_rpt_t got;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid                <= 1'b1;
    in_ch.opcode               <= cmd.opcode;
    in_ch.cmd_forward_velocity <= cmd.fwd;
    in_ch.cmd_angular_velocity <= cmd.ang;
    in_ch.load_x               <= cmd.lx;
    in_ch.load_y               <= cmd.ly;
    in_ch.load_heading         <= cmd.lh;
    do @(posedge clk); while (!in_ch.ready);
    got = advance_pose(cmd);
    pose_q.push_back(typed ? want : got);
  endtask

  // drain everything in flight, then write the step period
  task automatic program_period(input logic [PERIOD_W-1:0] p);
    in_ch.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    dt_q16 = p;
  endtask

  function automatic void row_cfg(input logic [PERIOD_W-1:0] p);
    dir_row_t r;
    r            = '{default: '0};
    r.set_period = 1'b1;
    r.period     = p;
    dir_tab.push_back(r);
  endfunction

  function automatic void row(input logic op, input logic signed [VEL_W-1:0] v,
                              input logic signed [ANGV_W-1:0] w,
                              input logic signed [POS_W-1:0] lx,
                              input logic signed [POS_W-1:0] ly,
                              input logic [HEAD_W-1:0] lh);
    dir_row_t r;
    r            = '{default: '0};
    r.cmd.opcode = op;
    r.cmd.fwd    = v;
    r.cmd.ang    = w;
    r.cmd.lx     = lx;
    r.cmd.ly     = ly;
    r.cmd.lh     = lh;
    dir_tab.push_back(r);
  endfunction

  function automatic void row_exp(input logic op, input logic signed [VEL_W-1:0] v,
                                  input logic signed [ANGV_W-1:0] w,
                                  input logic signed [POS_W-1:0] lx,
                                  input logic signed [POS_W-1:0] ly,
                                  input logic [HEAD_W-1:0] lh,
                                  input logic signed [POS_W-1:0] ex,
                                  input logic signed [POS_W-1:0] ey,
                                  input logic [HEAD_W-1:0] eh,
                                  input logic signed [VEL_W-1:0] elin,
                                  input logic signed [ANGV_W-1:0] eang);
    row(op, v, w, lx, ly, lh);
    dir_tab[$].typed    = 1'b1;
    dir_tab[$].want.x   = ex;
    dir_tab[$].want.y   = ey;
    dir_tab[$].want.hd  = eh;
    dir_tab[$].want.lin = elin;
    dir_tab[$].want.ang = eang;
  endfunction

  // result side: random stalls, one long hold-off to back the core up
  initial begin
    int        gap;
    pose_rpt_t exp_r;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (beats == HOLD_AT_BEAT) gap = HOLD_CYCLES;
      else gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      beats++;
      if (pose_q.size() == 0) begin
        $error("result beat with no pending item");
        errs++;
      end else begin
        exp_r = pose_q.pop_front();
        if (out_ch.out_x !== exp_r.x) begin
          $error("out_x: expected %0d, got %0d", exp_r.x, out_ch.out_x);
          errs++;
        end
        if (out_ch.out_y !== exp_r.y) begin
          $error("out_y: expected %0d, got %0d", exp_r.y, out_ch.out_y);
          errs++;
        end
        if (out_ch.out_heading !== exp_r.hd) begin
          $error("out_heading: expected %0d, got %0d", exp_r.hd, out_ch.out_heading);
          errs++;
        end
        if (out_ch.out_linear_velocity !== exp_r.lin) begin
          $error("out_linear_velocity: expected %0d, got %0d", exp_r.lin,
                 out_ch.out_linear_velocity);
          errs++;
        end
        if (out_ch.out_angular_velocity !== exp_r.ang) begin
          $error("out_angular_velocity: expected %0d, got %0d", exp_r.ang,
                 out_ch.out_angular_velocity);
          errs++;
        end
      end
    end
  end

  initial begin
    pose_cmd_t     c;
    pose_rpt_t     none;
    logic [PERIOD_W-1:0] p;
    no_idle = 1'b0;
    none    = '{default: '0};
    rst_n   = 1'b0;
    cfg_we  = 1'b0;
    cfg_wdata = '0;
    in_ch.valid                = 1'b0;
    in_ch.opcode               = OP_STEP;
    in_ch.cmd_forward_velocity = '0;
    in_ch.cmd_angular_velocity = '0;
    in_ch.load_x               = '0;
    in_ch.load_y               = '0;
    in_ch.load_heading         = '0;
    dt_q16  = STEP_PERIOD_RST;
    pose_x  = '0;
    pose_y  = '0;
    pose_hd = '0;

    // zero motion right after reset, then loads at the limits and saturating steps
    row_exp(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row_exp(OP_LOAD, 16'sh7fff, 24'sh123456, 32'sh7fffffff, 32'sh80000000, 16'hffff,
            32'sh7fffffff, 32'sh80000000, 16'hffff, 0, 0);
    row(OP_STEP, 16'sh7fff, 0, 0, 0, 0);
    row(OP_STEP, 16'sh8000, 24'sh800000, 32'sh7fffffff, 32'sh7fffffff, 16'hffff);
    row(OP_STEP, 16'sh7fff, 24'sh7fffff, 32'sh80000000, 32'sh80000000, 16'h0000);
    // fold boundaries of the heading
    row_exp(OP_LOAD, -1, -1, 0, 0, 16'h4000, 0, 0, 16'h4000, 0, 0);
    row(OP_STEP, 16'sh3200, 0, 0, 0, 0);
    row_exp(OP_LOAD, 0, 0, 0, 0, 16'h4001, 0, 0, 16'h4001, 0, 0);
    row(OP_STEP, 16'sh3200, 0, 0, 0, 0);
    row_exp(OP_LOAD, 0, 0, 0, 0, 16'hc000, 0, 0, 16'hc000, 0, 0);
    row(OP_STEP, 16'sh3200, 0, 0, 0, 0);
    row_exp(OP_LOAD, 0, 0, 0, 0, 16'hbfff, 0, 0, 16'hbfff, 0, 0);
    row(OP_STEP, 16'sh3200, 0, 0, 0, 0);
    row_exp(OP_LOAD, 0, 0, 0, 0, 16'h8000, 0, 0, 16'h8000, 0, 0);
    row(OP_STEP, 16'sh3200, 0, 0, 0, 0);
    // negative clamp on x while heading points backward
    row_exp(OP_LOAD, 0, 0, 32'sh80000001, 32'sh7ffffffe, 16'h8000,
            32'sh80000001, 32'sh7ffffffe, 16'h8000, 0, 0);
    row(OP_STEP, 16'sh7fff, 0, 0, 0, 0);
    // zero period freezes the pose but still echoes the velocities
    row_cfg(16'd0);
    row_exp(OP_LOAD, 0, 0, 1000, -1000, 16'h1234, 1000, -1000, 16'h1234, 0, 0);
    row_exp(OP_STEP, 12345, 24'sh800000, 0, 0, 0, 1000, -1000, 16'h1234, 12345, 24'sh800000);
    row_cfg(16'hffff);
    row(OP_STEP, 16'sh8000, 24'sh7fffff, 0, 0, 0);
    row(OP_STEP, 16'sh7fff, 24'sh800000, 0, 0, 0);
    row_cfg(16'd1);
    row(OP_STEP, 16'sh7fff, 24'sh7fffff, 0, 0, 0);
    row_cfg(STEP_PERIOD_RST);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_period) program_period(dir_tab[i].period);
      else send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: p = STEP_PERIOD_RST;
        1: p = 16'hffff;
        2: p = 16'd1;
        4: p = 16'h8000;
        6: p = STEP_PERIOD_RST;
        default: p = PERIOD_W'($urandom_range(1, 65535));
      endcase
      program_period(p);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        c.opcode = ($urandom_range(0, 99) < 12) ? OP_LOAD : OP_STEP;
        c.fwd = VEL_W'($urandom);
        if ($urandom_range(0, 3) == 0) c.fwd = c.fwd >>> 6;
        c.ang = ANGV_W'($urandom);
        if ($urandom_range(0, 2) == 0) c.ang = c.ang >>> 10;
        c.lx = $urandom;
        c.ly = $urandom;
        // park loads near the rails so steps run into saturation
        if ($urandom_range(0, 2) == 0)
          c.lx = c.lx[31] ? 32'sh80000000 + (c.lx & 32'h003fffff)
                          : 32'sh7fffffff - (c.lx & 32'h003fffff);
        if ($urandom_range(0, 2) == 0)
          c.ly = c.ly[31] ? 32'sh80000000 + (c.ly & 32'h003fffff)
                          : 32'sh7fffffff - (c.ly & 32'h003fffff);
        c.lh = HEAD_W'($urandom);
        if ($urandom_range(0, 4) == 0)
          c.lh = HEAD_W'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
        send_cmd(c, 1'b0, none);
      end
    end

    in_ch.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errs == 0) begin
      $display("unicycle_pose_integrator_core: match");
    end else begin
      $display("unicycle_pose_integrator_core: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ucpi_pkg.sv
src/ucpi_in_if.sv
src/ucpi_out_if.sv
src/ucpi_mult.sv
src/ucpi_cordic.sv
src/unicycle_pose_integrator_core.sv
sim/tb.sv
